>>> rtl/core/vdu_pkg.sv
// Package: shared widths, constants and codes for the vector distance unit.
package vdu_pkg;

	localparam int ELEM_W    = 16;   // element width, signed Q8.8
	localparam int DIFF_W    = ELEM_W + 1;
	localparam int ACC_W     = 42;   // dot and norm sums
	localparam int DSUM_W    = 44;   // sum of squared differences
	localparam int CNT_W     = 11;
	localparam int DIST_W    = 21;
	localparam int ROOT_W    = 22;   // root of a DSUM_W-bit value
	localparam int MUL_W     = 22;   // shared signed multiplier operand width
	localparam int PROD_W    = 2 * MUL_W;
	localparam int Q_FRAC    = 16;
	localparam int DIVN_W    = ACC_W + Q_FRAC;
	localparam int ONE_Q16   = 65536;
	localparam int MAX_LENGTH_DEF = 1024;

	localparam logic [DIST_W-1:0] DIST_SAT = '1;

	// configuration register indexes
	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_LEN  = 1'b1;

	// distance modes
	localparam logic MODE_COS = 1'b0;
	localparam logic MODE_L2  = 1'b1;

endpackage

>>> rtl/core/vdu_sqrt.sv
// Iterative truncating square root, two radicand bits per cycle.
module vdu_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vdu_pkg::DSUM_W-1:0]  radicand,
	output logic                        done,
	output logic [vdu_pkg::ROOT_W-1:0]  root
);
	import vdu_pkg::*;

	localparam int REM_W = ROOT_W + 4;

	logic [DSUM_W-1:0] rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W-1:0]  rem_n;
	logic [REM_W-1:0]  trial;
	logic              fits;

	always_comb begin
		rem_n = {rem_q[REM_W-3:0], rad_q[DSUM_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		fits  = (rem_n >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= 5'(ROOT_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[DSUM_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_n - trial) : rem_n;
			root_q <= {root_q[ROOT_W-2:0], fits};
			cnt_q  <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> rtl/core/vdu_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module vdu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vdu_pkg::DIVN_W-1:0]  dividend,
	input  logic [vdu_pkg::ACC_W-1:0]   divisor,
	output logic                        done,
	output logic [vdu_pkg::DIVN_W-1:0]  quotient
);
	import vdu_pkg::*;

	localparam int REM_W = ACC_W + 1;

	logic [DIVN_W-1:0] num_q;
	logic [DIVN_W-1:0] quot_q;
	logic [ACC_W-1:0]  den_q;
	logic [REM_W-1:0]  rem_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W-1:0]  rem_n;
	logic              fits;

	always_comb begin
		rem_n = {rem_q[REM_W-2:0], num_q[DIVN_W-1]};
		fits  = (rem_n >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			quot_q <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			num_q  <= dividend;
			den_q  <= divisor;
			quot_q <= '0;
			rem_q  <= '0;
			cnt_q  <= 6'(DIVN_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			num_q  <= {num_q[DIVN_W-2:0], 1'b0};
			rem_q  <= fits ? (rem_n - {1'b0, den_q}) : rem_n;
			quot_q <= {quot_q[DIVN_W-2:0], fits};
			cnt_q  <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

>>> rtl/core/vector_distance_unit_top.sv
// Top level: vector distance unit, shared multiplier under a sequencer.
//
// Streams element pairs on the s_ channel (s_tdata = elem_a, elem_b), one pair
// per transaction, and accumulates the dot product, both squared norms and
// the sum of squared differences. After vector_length pairs one distance leaves
// on the m_ channel: m_tdata carries distance (cosine Q2.16 or L2 root Q.8),
// m_tuser carries zero_norm.
// Configuration goes through the cfg_ channel (index 0 distance_mode, index 1
// vector_length); it is ready only while the block waits for a pair, so a write
// lands between pairs and never touches a pair in flight.
// One 22x22 signed multiplier serves the four products of each pair in turn,
// then s_tready returns. The last pair of a vector adds the finishing work:
// L2 runs one square root; cosine runs two square roots, the root product and
// the divider, and a zero norm in cosine mode skips straight to the result.
// The result sits in an output register; the sums clear when it is loaded and
// the next vector can start while it waits. A stalled receiver holds the block
// only when a newer result needs that register.
// Reset clears all sums, the pair count and the output register, and sets
// cosine mode with a vector length of 1.
module vector_distance_unit_top #(
	parameter int MAX_LENGTH = vdu_pkg::MAX_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // [15:0] elem_a, [31:16] elem_b
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [20:0] distance, [23:21] zero
	output logic        m_tuser,    // [0] zero_norm
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);
	import vdu_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4,
		ST_SQ_A, ST_SQ_B, ST_SQ_D, ST_MUL_DEN, ST_DEN, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;

	logic              mode_q;
	logic [CNT_W-1:0]  len_q;

	logic [ELEM_W-1:0] a_q, b_q;
	logic [ACC_W-1:0]  dot_q, na_q, nb_q;
	logic [DSUM_W-1:0] dsum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ROOT_W-1:0] ra_q;
	logic              neg_q;
	logic [PROD_W-1:0] prod_s1;

	logic              sq_start_q, div_start_q;
	logic [DSUM_W-1:0] sq_rad_q;
	logic [DIVN_W-1:0] div_num_q;
	logic [ACC_W-1:0]  div_den_q;

	logic              res_valid_q;
	logic [DIST_W-1:0] res_dist_q, dist_n;
	logic              res_zn_q;
	logic [DIST_W-1:0] fin_dist_q;
	logic              fin_zn_q;

	logic              sq_done, div_done;
	logic [ROOT_W-1:0] sq_root;
	logic [DIVN_W-1:0] quot;

	logic signed [MUL_W-1:0] mul_x, mul_y;
	logic [DIFF_W-1:0] diff;
	logic [CNT_W-1:0]  cnt_n, len_eff;
	logic              vec_done;
	logic [ACC_W-1:0]  dot_mag;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	assign diff = {a_q[ELEM_W-1], a_q} - {b_q[ELEM_W-1], b_q};

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			ST_M0: begin
				mul_x = MUL_W'(signed'(a_q));
				mul_y = MUL_W'(signed'(b_q));
			end
			ST_M1: begin
				mul_x = MUL_W'(signed'(a_q));
				mul_y = MUL_W'(signed'(a_q));
			end
			ST_M2: begin
				mul_x = MUL_W'(signed'(b_q));
				mul_y = MUL_W'(signed'(b_q));
			end
			ST_M3: begin
				mul_x = MUL_W'(signed'(diff));
				mul_y = MUL_W'(signed'(diff));
			end
			default: begin
				mul_x = signed'(ra_q);
				mul_y = signed'(sq_root);
			end
		endcase
	end

	always_comb begin
		cnt_n = cnt_q + CNT_W'(1);
		if (len_q == '0)
			len_eff = CNT_W'(1);
		else if (int'(len_q) > MAX_LENGTH)
			len_eff = CNT_W'(MAX_LENGTH);
		else
			len_eff = len_q;
		vec_done = (cnt_n >= len_eff) || (cnt_n == '0);
		dot_mag  = dot_q[ACC_W-1] ? (~dot_q + ACC_W'(1)) : dot_q;
	end

	// signed quotient applied to 1.0 and clamped to 0..2.0
	always_comb begin
		if (neg_q) begin
			if (quot > DIVN_W'(ONE_Q16))
				dist_n = DIST_W'(2 * ONE_Q16);
			else
				dist_n = DIST_W'(ONE_Q16) + DIST_W'(quot[Q_FRAC:0]);
		end else begin
			if (quot >= DIVN_W'(ONE_Q16))
				dist_n = '0;
			else
				dist_n = DIST_W'(ONE_Q16) - DIST_W'(quot[Q_FRAC-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s1 <= '0;
		end else begin
			prod_s1 <= PROD_W'(mul_x * mul_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_COS;
			len_q       <= CNT_W'(1);
			a_q         <= '0;
			b_q         <= '0;
			dot_q       <= '0;
			na_q        <= '0;
			nb_q        <= '0;
			dsum_q      <= '0;
			cnt_q       <= '0;
			ra_q        <= '0;
			neg_q       <= 1'b0;
			sq_start_q  <= 1'b0;
			div_start_q <= 1'b0;
			sq_rad_q    <= '0;
			div_num_q   <= '0;
			div_den_q   <= '0;
			res_valid_q <= 1'b0;
			res_dist_q  <= '0;
			res_zn_q    <= 1'b0;
			fin_dist_q  <= '0;
			fin_zn_q    <= 1'b0;
		end else begin
			sq_start_q  <= 1'b0;
			div_start_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[0];
					CFG_LEN:  len_q  <= cfg_data;
					default:  ;
				endcase
			end

			// drop the result once the receiver takes it; ST_OUT reloads it itself
			if (res_valid_q && m_tready && state_q != ST_OUT)
				res_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						a_q     <= s_tdata[ELEM_W-1:0];
						b_q     <= s_tdata[2*ELEM_W-1:ELEM_W];
						state_q <= ST_M0;
					end
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: begin
					dot_q   <= dot_q + prod_s1[ACC_W-1:0];
					state_q <= ST_M2;
				end
				ST_M2: begin
					na_q    <= na_q + prod_s1[ACC_W-1:0];
					state_q <= ST_M3;
				end
				ST_M3: begin
					nb_q    <= nb_q + prod_s1[ACC_W-1:0];
					state_q <= ST_M4;
				end
				ST_M4: begin
					dsum_q <= dsum_q + prod_s1[DSUM_W-1:0];
					cnt_q  <= cnt_n;
					if (!vec_done) begin
						state_q <= ST_IDLE;
					end else if (mode_q == MODE_L2) begin
						sq_rad_q   <= dsum_q + prod_s1[DSUM_W-1:0];
						sq_start_q <= 1'b1;
						state_q    <= ST_SQ_D;
					end else if (na_q == '0 || nb_q == '0) begin
						fin_dist_q <= '0;
						fin_zn_q   <= 1'b1;
						state_q    <= ST_OUT;
					end else begin
						sq_rad_q   <= DSUM_W'(na_q);
						sq_start_q <= 1'b1;
						state_q    <= ST_SQ_A;
					end
				end
				ST_SQ_D: begin
					if (sq_done) begin
						fin_dist_q <= sq_root[ROOT_W-1] ? DIST_SAT : sq_root[DIST_W-1:0];
						fin_zn_q   <= 1'b0;
						state_q    <= ST_OUT;
					end
				end
				ST_SQ_A: begin
					if (sq_done) begin
						ra_q       <= sq_root;
						sq_rad_q   <= DSUM_W'(nb_q);
						sq_start_q <= 1'b1;
						state_q    <= ST_SQ_B;
					end
				end
				ST_SQ_B: begin
					if (sq_done)
						state_q <= ST_MUL_DEN;
				end
				ST_MUL_DEN: state_q <= ST_DEN;
				ST_DEN: begin
					neg_q       <= dot_q[ACC_W-1];
					div_num_q   <= {dot_mag, Q_FRAC'(0)};
					div_den_q   <= prod_s1[ACC_W-1:0];
					div_start_q <= 1'b1;
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						fin_dist_q <= dist_n;
						fin_zn_q   <= 1'b0;
						state_q    <= ST_OUT;
					end
				end
				ST_OUT: begin
					// load the output register and clear the sums
					if (!res_valid_q || m_tready) begin
						res_valid_q <= 1'b1;
						res_dist_q  <= fin_dist_q;
						res_zn_q    <= fin_zn_q;
						dot_q       <= '0;
						na_q        <= '0;
						nb_q        <= '0;
						dsum_q      <= '0;
						cnt_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	vdu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start_q),
		.radicand (sq_rad_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	vdu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_num_q),
		.divisor  (div_den_q),
		.done     (div_done),
		.quotient (quot)
	);

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {3'b000, res_dist_q};
	assign m_tuser  = res_zn_q;

endmodule
